// ===== hw/rtl/traffic_signal_select_vote_defines.svh =====
// assertion macros for the traffic signal select and vote block
// used by the top level only, no other dependencies
`ifndef TRAFFIC_SIGNAL_SELECT_VOTE_DEFINES_SVH
`define TRAFFIC_SIGNAL_SELECT_VOTE_DEFINES_SVH

// property that holds at every edge out of reset
`define TSSV_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("tssv check failed");

// same-cycle implication
`define TSSV_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("tssv check failed");

`endif

// ===== hw/rtl/tssv_pkg.sv =====
// shared constants, codes and types for the traffic signal select and vote block
// no dependencies
package tssv_pkg;

   // sizes
   localparam int HISTORY_DEPTH_DEF = 5;
   localparam int STABLE_VOTES_DEF  = 3;
   localparam int QUEUE_DEPTH       = 4;

   // configuration register indexes
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;
   localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
   localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;

   // detection classes
   localparam logic [3:0] CLS_OTHER       = 4'd0;
   localparam logic [3:0] CLS_PLAIN_LAST  = 4'd4;
   localparam logic [3:0] CLS_RED_BASE    = 4'd4;
   localparam logic [3:0] CLS_RED_LAST    = 4'd8;
   localparam logic [3:0] CLS_GREEN_BASE  = 4'd8;
   localparam logic [3:0] CLS_GREEN_LAST  = 4'd12;

   // signal states and directions
   localparam logic [2:0] STATE_NONE  = 3'd0;
   localparam logic [2:0] STATE_RED   = 3'd1;
   localparam logic [2:0] STATE_GREEN = 3'd3;
   localparam logic [2:0] DIR_NONE    = 3'd0;

   // fixed point constants (q16)
   localparam logic [19:0] TERM_MUL  = 20'd688128;  // 0.42 * 65536 * 25 / 2 * 2
   localparam logic [14:0] BONUS_CAP = 15'd16384;
   localparam logic signed [19:0] REL_RESET = -20'sd65536;

   // gate factors on half-pixel centres (x25)
   localparam logic [5:0] GATE_SCALE = 6'd25;
   localparam logic [5:0] GATE_LOW   = 6'd34;
   localparam logic [5:0] GATE_LEFT  = 6'd6;
   localparam logic [5:0] GATE_RIGHT = 6'd44;

   // divider shapes
   localparam int TERM_NW  = 34;
   localparam int TERM_DW  = 18;
   localparam int BONUS_NW = 28;
   localparam int BONUS_DW = 13;
   localparam int QUOT_W   = 15;

   // classified word passed from front to back
   typedef struct packed {
      logic        light;
      logic        last;
      logic [2:0]  st;
      logic [2:0]  dir;
      logic [11:0] box_x;
      logic [11:0] box_y;
      logic [11:0] box_w;
      logic [11:0] box_h;
      logic [15:0] score;
      logic [13:0] ctr_off;
   } q_entry_type;

   // queue status seen by the front
   typedef struct packed {
      logic full;
      logic valid;
   } q_stat_type;

endpackage

// ===== hw/rtl/traffic_signal_select_vote.sv =====
// Traffic light selection per frame with a majority vote over recent frames.
// Sequence: a gated-out word is popped without scoring; a light is popped and then scored
// by two 15-step dividers in parallel; the last word of a frame is followed by the push,
// the vote scan and the result load, which waits while the last result is not yet taken.
// The back end takes no new word until the dividers have finished with the last light.
// Reset (sync, active high): 640x480, clears best light, fill, queue, result; not history.
module traffic_signal_select_vote #(
   parameter int HISTORY_DEPTH = tssv_pkg::HISTORY_DEPTH_DEF,
   parameter int STABLE_VOTES  = tssv_pkg::STABLE_VOTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // det_class, box_x, box_y, box_w, box_h, det_score, zero pad
   input  logic        req_tlast,   // last_in_frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // signal_state, signal_dir, out_x, out_y, out_w, out_h,
                                    // out_score, stable, zero pad
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [12:0] csr_wdata
);
   import tssv_pkg::*;
   `include "traffic_signal_select_vote_defines.svh"

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [12:0] frame_width_ff;
   logic [12:0] frame_height_ff;
   q_entry_type q_in, q_out;
   q_stat_type  q_stat;
   logic        q_push, q_pop;
   logic [CW-1:0] q_count;
   logic [$clog2(HISTORY_DEPTH+1)-1:0] hist_fill;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   tssv_front u_front (
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .frame_width(frame_width_ff), .frame_height(frame_height_ff),
      .q_stat(q_stat), .q_push(q_push), .q_word(q_in)
   );

   tssv_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock(clock), .reset(reset), .push(q_push), .wdata(q_in), .pop(q_pop),
      .rdata(q_out), .stat(q_stat), .count(q_count)
   );

   tssv_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .STABLE_VOTES(STABLE_VOTES)) u_back (
      .clock(clock), .reset(reset), .frame_width(frame_width_ff),
      .frame_height(frame_height_ff), .q_stat(q_stat), .q_word(q_out), .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .hist_fill(hist_fill)
   );

   // checks
   `TSSV_ASSERT_IMP(a_stable_has_state, clock, reset, rsp_tvalid && rsp_tdata[70], rsp_tdata[2:0] != STATE_NONE)
   `TSSV_ASSERT_ALWAYS(a_fill_bounded, clock, reset, 32'(hist_fill) <= HISTORY_DEPTH)
   `TSSV_ASSERT_IMP(a_ready_tracks_queue, clock, reset, req_tready, q_count != CW'(QUEUE_DEPTH))
endmodule

// ===== hw/rtl/tssv_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on nothing; quotient is known to fit in QW bits
module tssv_div #(
   parameter int NW = 34,
   parameter int DW = 18,
   parameter int QW = 15
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [QW-1:0] quot
);
   localparam int CW = $clog2(QW + 1);

   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [QW-1:0] low_ff;
   logic [QW-1:0] quot_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [DW:0]   trial;
   logic          ge;

   // trial subtract of the next bit
   assign trial = {rem_ff, low_ff[QW-1]};
   assign ge    = trial >= {1'b0, den_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(QW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DW'(num >> QW);
         low_ff <= num[QW-1:0];
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff  <= ge ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
         low_ff  <= {low_ff[QW-2:0], 1'b0};
         quot_ff <= {quot_ff[QW-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

// ===== hw/rtl/tssv_fifo.sv =====
// short queue between the classifying front and the scoring back
// depends on tssv_pkg for the word type
module tssv_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tssv_pkg::q_entry_type wdata,
   input  logic                  pop,
   output tssv_pkg::q_entry_type rdata,
   output tssv_pkg::q_stat_type  stat,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import tssv_pkg::*;
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   q_entry_type   mem_ff [DEPTH];
   logic [PW-1:0] wptr_ff;
   logic [PW-1:0] rptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push;
   logic          do_pop;

   assign do_push = push && (count_ff != CW'(DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wptr_ff <= (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         if (do_pop)  rptr_ff <= (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wptr_ff] <= wdata;
   end

   assign rdata      = mem_ff[rptr_ff];
   assign stat.full  = count_ff == CW'(DEPTH);
   assign stat.valid = count_ff != '0;
   assign count      = count_ff;
endmodule

// ===== hw/rtl/tssv_front.sv =====
// front end: takes detection words, decodes class and applies position gates
// depends on tssv_pkg; feeds tssv_fifo
module tssv_front (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [71:0]           req_tdata,
   input  logic                  req_tlast,
   input  logic [12:0]           frame_width,
   input  logic [12:0]           frame_height,
   input  tssv_pkg::q_stat_type  q_stat,
   output logic                  q_push,
   output tssv_pkg::q_entry_type q_word
);
   import tssv_pkg::*;

   logic [3:0]  cls;
   logic [11:0] bx, by, bw, bh;
   logic [13:0] cx2, cy2, w14;
   logic [18:0] cx25, cy25, low_lim, left_lim, right_lim;
   logic        is_light;
   logic        gated;
   logic [2:0]  st, dir;

   // field split
   assign cls = req_tdata[3:0];
   assign bx  = req_tdata[15:4];
   assign by  = req_tdata[27:16];
   assign bw  = req_tdata[39:28];
   assign bh  = req_tdata[51:40];

   // half-pixel centres and gate limits
   assign cx2       = {1'b0, bx, 1'b0} + 14'(bw);
   assign cy2       = {1'b0, by, 1'b0} + 14'(bh);
   assign w14       = 14'(frame_width);
   assign cx25      = 19'(cx2) * 19'(GATE_SCALE);
   assign cy25      = 19'(cy2) * 19'(GATE_SCALE);
   assign low_lim   = 19'(frame_height) * 19'(GATE_LOW);
   assign left_lim  = 19'(frame_width) * 19'(GATE_LEFT);
   assign right_lim = 19'(frame_width) * 19'(GATE_RIGHT);
   assign gated     = (cy25 > low_lim) || (cx25 < left_lim) || (cx25 > right_lim);

   // class decode
   always_comb begin
      is_light = 1'b1;
      st       = STATE_NONE;
      dir      = DIR_NONE;
      priority if (cls == CLS_OTHER || cls > CLS_GREEN_LAST) begin
         is_light = 1'b0;
      end else if (cls <= CLS_PLAIN_LAST) begin
         st = cls[2:0];
      end else if (cls <= CLS_RED_LAST) begin
         st  = STATE_RED;
         dir = 3'(cls - CLS_RED_BASE);
      end else begin
         st  = STATE_GREEN;
         dir = 3'(cls - CLS_GREEN_BASE);
      end
   end

   // handshake and word build
   assign req_tready     = !q_stat.full;
   assign q_push         = req_tvalid && !q_stat.full;
   assign q_word.light   = is_light && !gated;
   assign q_word.last    = req_tlast;
   assign q_word.st      = st;
   assign q_word.dir     = dir;
   assign q_word.box_x   = bx;
   assign q_word.box_y   = by;
   assign q_word.box_w   = bw;
   assign q_word.box_h   = bh;
   assign q_word.score   = req_tdata[67:52];
   assign q_word.ctr_off = (cx2 >= w14) ? cx2 - w14 : w14 - cx2;
endmodule

// ===== hw/rtl/tssv_back.sv =====
// back end: relevance scoring, best-light tracking, history vote and result register
// depends on tssv_pkg and tssv_div
module tssv_back #(
   parameter int HISTORY_DEPTH = tssv_pkg::HISTORY_DEPTH_DEF,
   parameter int STABLE_VOTES  = tssv_pkg::STABLE_VOTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [12:0]           frame_width,
   input  logic [12:0]           frame_height,
   input  tssv_pkg::q_stat_type  q_stat,
   input  tssv_pkg::q_entry_type q_word,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,
   output logic [$clog2(HISTORY_DEPTH+1)-1:0] hist_fill
);
   import tssv_pkg::*;
   localparam int IW = $clog2(HISTORY_DEPTH);
   localparam int FW = $clog2(HISTORY_DEPTH + 1);

   typedef enum logic [2:0] {S_IDLE, S_DIV, S_PUSH, S_VOTE, S_OUT} state_type;

   state_type          state_ff;
   q_entry_type        item_ff;
   logic signed [19:0] best_rel_ff;
   logic [2:0]         best_st_ff, best_dir_ff;
   logic [11:0]        best_x_ff, best_y_ff, best_w_ff, best_h_ff;
   logic [15:0]        best_score_ff;
   logic [5:0]         hist_ff [HISTORY_DEPTH];
   logic [FW-1:0]      fill_ff;
   logic [IW-1:0]      wptr_ff;
   logic [IW-1:0]      vidx_ff;
   logic [FW-1:0]      top_cnt_ff;
   logic [5:0]         top_key_ff;
   logic               rsp_valid_ff;
   logic [71:0]        rsp_data_ff;

   logic               div_start;
   logic [TERM_NW-1:0] term_num;
   logic [TERM_DW-1:0] term_den;
   logic [BONUS_NW-1:0] bonus_num;
   logic               term_done, bonus_done;
   logic [QUOT_W-1:0]  term_q, bonus_q;
   logic [14:0]        term, bonus;
   logic signed [19:0] rel;
   logic [5:0]         vkey;
   logic [FW-1:0]      vcnt;
   logic               veligible, vbetter, stable, out_free;
   logic [2:0]         out_st, out_dir;

   // pop one word whenever the sequencer is idle
   assign q_pop     = (state_ff == S_IDLE) && q_stat.valid;
   assign div_start = q_pop && q_word.light;
   assign term_num  = TERM_NW'(q_word.ctr_off) * TERM_NW'(TERM_MUL);
   assign term_den  = TERM_DW'(frame_width) * TERM_DW'(GATE_SCALE);
   assign bonus_num = {q_word.box_h, 16'd0};

   // centre penalty and size bonus dividers run side by side
   tssv_div #(.NW(TERM_NW), .DW(TERM_DW), .QW(QUOT_W)) u_term_div (
      .clock(clock), .reset(reset), .start(div_start), .num(term_num),
      .den(term_den), .done(term_done), .quot(term_q)
   );

   tssv_div #(.NW(BONUS_NW), .DW(BONUS_DW), .QW(QUOT_W)) u_bonus_div (
      .clock(clock), .reset(reset), .start(div_start), .num(bonus_num),
      .den(frame_height), .done(bonus_done), .quot(bonus_q)
   );

   // relevance of the current light
   assign term  = (frame_width == '0) ? 15'd0 : term_q;
   assign bonus = ({item_ff.box_h, 2'b00} >= 14'(frame_height)) ? BONUS_CAP : bonus_q;
   assign rel   = $signed({4'd0, item_ff.score}) + $signed({5'd0, bonus})
                - $signed({5'd0, term});

   // votes for the history entry under the scan index
   assign vkey = hist_ff[vidx_ff];
   always_comb begin
      vcnt = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         if ((FW'(i) < fill_ff) && (hist_ff[i] == vkey)) vcnt = vcnt + 1'b1;
      end
   end
   assign veligible = (FW'(vidx_ff) < fill_ff) && (vkey[5:3] != STATE_NONE);
   assign vbetter   = (vcnt > top_cnt_ff) || ((vcnt == top_cnt_ff) && (vkey < top_key_ff));

   // final state and direction
   assign stable   = 32'(top_cnt_ff) >= STABLE_VOTES;
   assign out_st   = stable ? top_key_ff[5:3] : best_st_ff;
   assign out_dir  = stable ? top_key_ff[2:0] : best_dir_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // history store, no reset: entries beyond the fill level are never counted
   always_ff @(posedge clock) begin
      if (state_ff == S_PUSH) hist_ff[wptr_ff] <= {best_st_ff, best_dir_ff};
   end

   // sequencer, best light and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         best_rel_ff   <= REL_RESET;
         best_st_ff    <= STATE_NONE;
         best_dir_ff   <= DIR_NONE;
         best_x_ff     <= '0;
         best_y_ff     <= '0;
         best_w_ff     <= '0;
         best_h_ff     <= '0;
         best_score_ff <= '0;
         fill_ff       <= '0;
         wptr_ff       <= '0;
         vidx_ff       <= '0;
         top_cnt_ff    <= '0;
         top_key_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // result taken; in the load state the new word is written below instead
         if (rsp_valid_ff && rsp_tready && (state_ff != S_OUT)) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  item_ff <= q_word;
                  if (q_word.light)     state_ff <= S_DIV;
                  else if (q_word.last) state_ff <= S_PUSH;
               end
            end
            S_DIV: begin
               if (term_done && bonus_done) begin
                  if (rel > best_rel_ff) begin
                     best_rel_ff   <= rel;
                     best_st_ff    <= item_ff.st;
                     best_dir_ff   <= item_ff.dir;
                     best_x_ff     <= item_ff.box_x;
                     best_y_ff     <= item_ff.box_y;
                     best_w_ff     <= item_ff.box_w;
                     best_h_ff     <= item_ff.box_h;
                     best_score_ff <= item_ff.score;
                  end
                  state_ff <= item_ff.last ? S_PUSH : S_IDLE;
               end
            end
            S_PUSH: begin
               wptr_ff    <= (wptr_ff == IW'(HISTORY_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
               if (fill_ff < FW'(HISTORY_DEPTH)) fill_ff <= fill_ff + 1'b1;
               vidx_ff    <= '0;
               top_cnt_ff <= '0;
               top_key_ff <= '0;
               state_ff   <= S_VOTE;
            end
            S_VOTE: begin
               if (veligible && vbetter) begin
                  top_cnt_ff <= vcnt;
                  top_key_ff <= vkey;
               end
               if (vidx_ff == IW'(HISTORY_DEPTH - 1)) state_ff <= S_OUT;
               else vidx_ff <= vidx_ff + 1'b1;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_data_ff   <= {1'b0, stable, best_score_ff, best_h_ff, best_w_ff,
                                    best_y_ff, best_x_ff, out_dir, out_st};
                  best_rel_ff   <= REL_RESET;
                  best_st_ff    <= STATE_NONE;
                  best_dir_ff   <= DIR_NONE;
                  best_x_ff     <= '0;
                  best_y_ff     <= '0;
                  best_w_ff     <= '0;
                  best_h_ff     <= '0;
                  best_score_ff <= '0;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign hist_fill  = fill_ff;
endmodule

// ===== tb/sv/traffic_signal_select_vote_tb.sv =====
// Self-checking testbench for traffic_signal_select_vote: streams frames of detections,
// predicts the per-frame signal choice and vote, and checks every result word.
// Depends on tssv_pkg and the traffic_signal_select_vote top level.
`timescale 1ns / 100ps

module traffic_signal_select_vote_tb;
   import tssv_pkg::*;

   localparam int CYCLE_LIMIT    = 1000000;
   localparam int PHASE_ITEMS    = 190;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 500;
   localparam int HDEPTH         = HISTORY_DEPTH_DEF;
   localparam int HVOTES         = STABLE_VOTES_DEF;

   typedef struct {
      bit [3:0]  cls;
      bit [11:0] x, y, w, h;
      bit [15:0] sc;
      bit        last;
      bit        typed;   // expected result is all zero, written here
   } detection_type;

   typedef struct packed {
      bit [2:0]  state;
      bit [2:0]  dir;
      bit [11:0] x, y, w, h;
      bit [15:0] score;
      bit        stable;
   } signal_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        csr_we;
   logic        csr_addr;
   logic [12:0] csr_wdata;

   traffic_signal_select_vote dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // predictor state
   int unsigned  pw, ph;
   int           top_rel;
   bit [2:0]     top_state, top_dir;
   bit [11:0]    top_x, top_y, top_w, top_h;
   bit [15:0]    top_score;
   bit [5:0]     votes [HDEPTH];
   int unsigned  vote_fill, vote_ptr;

   signal_type   pending_signals [$];
   int           mismatches;
   int unsigned  cycles;
   int unsigned  signals_seen;

   detection_type directed [$];

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic void clear_top();
      top_rel = -65536;
      top_state = STATE_NONE;
      top_dir = DIR_NONE;
      top_x = 0; top_y = 0; top_w = 0; top_h = 0;
      top_score = 0;
   endfunction

   // selection of the most relevant light, then the vote at frame end
   function automatic bit predict_signal(detection_type d, output signal_type s);
      longint unsigned cx2, cy2, ctr_off, term, bonus, w, h;
      int rel, cnt, best_cnt;
      bit [5:0] best_key, key;
      w = pw; h = ph;
      best_cnt = 0; best_key = 0;
      s = '{default: 0};
      if (d.cls != CLS_OTHER && d.cls <= CLS_GREEN_LAST) begin
         cx2 = 2 * longint'(d.x) + d.w;
         cy2 = 2 * longint'(d.y) + d.h;
         if (!(25 * cy2 > 34 * h || 25 * cx2 < 6 * w || 25 * cx2 > 44 * w)) begin
            ctr_off = (cx2 >= w) ? cx2 - w : w - cx2;
            term = (w == 0) ? 0 : (ctr_off * 688128) / (25 * w);
            bonus = (h == 0) ? 16384 : (longint'(d.h) * 65536) / h;
            if (bonus > 16384) bonus = 16384;
            rel = int'(d.sc) + int'(bonus) - int'(term);
            if (rel > top_rel) begin
               top_rel = rel;
               if (d.cls <= CLS_PLAIN_LAST) begin
                  top_state = d.cls[2:0];
                  top_dir = DIR_NONE;
               end else if (d.cls <= CLS_RED_LAST) begin
                  top_state = STATE_RED;
                  top_dir = 3'(d.cls - CLS_RED_BASE);
               end else begin
                  top_state = STATE_GREEN;
                  top_dir = 3'(d.cls - CLS_GREEN_BASE);
               end
               top_x = d.x; top_y = d.y; top_w = d.w; top_h = d.h;
               top_score = d.sc;
            end
         end
      end
      if (!d.last) return 1'b0;

      votes[vote_ptr] = {top_state, top_dir};
      vote_ptr = (vote_ptr + 1) % HDEPTH;
      if (vote_fill < HDEPTH) vote_fill++;
      // smaller state, then smaller direction, wins a tie
      for (int st = 1; st < 8; st++) begin
         for (int dr = 0; dr < 8; dr++) begin
            key = {3'(st), 3'(dr)};
            cnt = 0;
            for (int i = 0; i < vote_fill; i++)
               if (votes[i] == key) cnt++;
            if (cnt > best_cnt) begin
               best_cnt = cnt;
               best_key = key;
            end
         end
      end
      s.stable = (best_cnt >= HVOTES);
      s.state = s.stable ? best_key[5:3] : top_state;
      s.dir = s.stable ? best_key[2:0] : top_dir;
      s.x = top_x; s.y = top_y; s.w = top_w; s.h = top_h;
      s.score = top_score;
      clear_top();
      return 1'b1;
   endfunction

   // add a row to the directed table
   function automatic void add_row(detection_type d);
      directed.insert(directed.size(), d);
   endfunction

   // offer one word, keep tvalid high on return
   task automatic send_detection(detection_type d);
      int gap;
      signal_type s;
      gap = $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, d.sc, d.h, d.w, d.y, d.x, d.cls};
      req_tlast <= d.last;
      do @(posedge clock); while (!req_tready);
      if (predict_signal(d, s)) begin
         if (d.typed) s = '{default: 0};
         pending_signals.insert(pending_signals.size(), s);
      end
   endtask

   task automatic drain_signals();
      req_tvalid <= 1'b0;
      while (pending_signals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_size(int unsigned w, int unsigned h);
      csr_we <= 1'b1;
      csr_addr <= CSR_FRAME_WIDTH;
      csr_wdata <= 13'(w);
      @(posedge clock);
      csr_addr <= CSR_FRAME_HEIGHT;
      csr_wdata <= 13'(h);
      @(posedge clock);
      csr_we <= 1'b0;
      pw = w; ph = h;
   endtask

   function automatic detection_type mk(bit [3:0] c, bit [11:0] x, bit [11:0] y,
                                        bit [11:0] w, bit [11:0] h, bit [15:0] sc,
                                        bit last, bit typed);
      detection_type d;
      d.cls = c; d.x = x; d.y = y; d.w = w; d.h = h; d.sc = sc; d.last = last;
      d.typed = typed;
      return d;
   endfunction

   function automatic int unsigned cap(int unsigned v);
      return (v > 4095) ? 4095 : v;
   endfunction

   // random detection, mostly a light placed inside the usable area
   function automatic detection_type random_detection(bit [3:0] c, bit noise);
      detection_type d;
      if (noise) begin
         d.cls = 4'($urandom); d.x = 12'($urandom); d.y = 12'($urandom);
         d.w = 12'($urandom); d.h = 12'($urandom);
      end else begin
         d.cls = c;
         d.x = 12'($urandom_range(0, cap(pw)));
         d.w = 12'($urandom_range(0, cap(pw / 3 + 1)));
         d.y = 12'($urandom_range(0, cap(ph * 2 / 3)));
         d.h = 12'($urandom_range(0, cap(ph / 3 + 1)));
      end
      d.sc = 16'($urandom);
      d.last = 1'b0;
      d.typed = 1'b0;
      return d;
   endfunction

   // result side: random stalls and one long hold-off
   initial begin
      int gap;
      signal_type got, want;
      rsp_tready = 1'b0;
      signals_seen = 0;
      mismatches = 0;
      @(negedge reset);
      forever begin
         gap = (signals_seen == 30) ? HOLD_CYCLES : $urandom_range(0, 15);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         signals_seen++;
         got.state = rsp_tdata[2:0];   got.dir = rsp_tdata[5:3];
         got.x = rsp_tdata[17:6];      got.y = rsp_tdata[29:18];
         got.w = rsp_tdata[41:30];     got.h = rsp_tdata[53:42];
         got.score = rsp_tdata[69:54]; got.stable = rsp_tdata[70];
         if (pending_signals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %p", got);
         end else begin
            want = pending_signals[0];
            pending_signals.delete(0);
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
            end
         end
      end
   end

   // stimulus
   initial begin
      int unsigned widths [$], heights [$];
      int n, items, guard;
      bit [3:0] fcls;
      detection_type d;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tlast = 1'b0;
      csr_we = 1'b0; csr_addr = CSR_FRAME_WIDTH; csr_wdata = '0;
      pw = FRAME_WIDTH_RST; ph = FRAME_HEIGHT_RST;
      clear_top();
      vote_fill = 0; vote_ptr = 0;
      foreach (votes[i]) votes[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // frames that give no light, then each class alone, then a vote
      add_row(mk(CLS_OTHER, 0, 0, 0, 0, 0, 1, 1));
      add_row(mk(13, 300, 100, 40, 80, 40000, 1, 1));
      add_row(mk(15, 300, 100, 40, 80, 40000, 1, 1));
      add_row(mk(12, 4095, 4095, 4095, 4095, 65535, 1, 1));
      add_row(mk(1, 0, 0, 0, 0, 65535, 1, 1));
      add_row(mk(7, 600, 100, 40, 40, 30000, 1, 1));
      for (int c = 1; c <= 12; c++)
         add_row(mk(4'(c), 300, 100, 40, 80, (c % 2) ? 16'hFFFF : 16'h0, 1, 0));
      repeat (3) add_row(mk(5, 310, 120, 20, 30, 50000, 1, 0));
      add_row(mk(9, 300, 100, 40, 80, 20000, 0, 0));
      add_row(mk(2, 300, 100, 40, 80, 20000, 0, 0));
      add_row(mk(3, 320, 0, 0, 0, 0, 1, 0));
      foreach (directed[i]) send_detection(directed[i]);
      drain_signals();

      widths  = '{640, 1, 4096, 4096, 1, 1920, 0, 0};
      heights = '{480, 1, 4096, 1, 4096, 1080, 0, 0};
      for (int p = 0; p < widths.size(); p++) begin
         if (p >= 6) begin
            widths[p] = $urandom_range(1, 4096);
            heights[p] = $urandom_range(1, 4096);
         end
         write_frame_size(widths[p], heights[p]);
         items = 0;
         fcls = 4'($urandom_range(1, 12));
         while (items < PHASE_ITEMS) begin
            n = $urandom_range(1, 6);
            // keep a class for a few frames so the vote can settle
            if ($urandom_range(0, 9) < 4) fcls = 4'($urandom_range(1, 12));
            for (int k = 0; k < n; k++) begin
               d = random_detection(($urandom_range(0, 2) == 0) ?
                                    4'($urandom_range(0, 15)) : fcls,
                                    $urandom_range(0, 9) == 0);
               d.last = (k == n - 1);
               send_detection(d);
               items++;
            end
         end
         drain_signals();
      end

      guard = 0;
      while (pending_signals.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_signals.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tssv_pkg.sv
hw/rtl/tssv_div.sv
hw/rtl/tssv_fifo.sv
hw/rtl/tssv_front.sv
hw/rtl/tssv_back.sv
hw/rtl/traffic_signal_select_vote.sv
tb/sv/traffic_signal_select_vote_tb.sv
